// ===== rtl/rbsi_pkg.sv =====
// Package for the ray/box slab intersect block: widths, codes, helpers.
// No dependencies.
`default_nettype none
package rbsi_pkg;
    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 34;               // slab numerator width
    localparam int DIVD_W    = NUM_W + FRAC_BITS; // dividend magnitude width
    localparam int DIV_W     = 32;               // divisor magnitude width
    localparam int T_W       = 64;               // slab time width

    localparam logic [2:0] NRM_NONE = 3'd0;
    localparam logic [2:0] NRM_PX   = 3'd1;
    localparam logic [2:0] NRM_NX   = 3'd2;
    localparam logic [2:0] NRM_PY   = 3'd3;
    localparam logic [2:0] NRM_NY   = 3'd4;

    localparam logic signed [T_W-1:0] T_UNB = 64'sd4611686018427387904;
    localparam logic signed [T_W-1:0] PROD_CAP = 64'sd1099511627776;

    function automatic logic signed [31:0] sat32(input logic signed [T_W-1:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, floor result.
// Depends on rbsi_pkg.
`default_nettype none
module rbsi_div
    import rbsi_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_vld,
    input  wire logic signed [NUM_W-1:0]   num,
    input  wire logic signed [31:0]        den,
    output logic signed [T_W-1:0]          quo
);
    localparam int N = DIVD_W;
    logic [N-1:0]   q_reg [0:N];
    logic [DIV_W:0] r_reg [0:N];
    logic [DIV_W-1:0] d_reg [0:N];
    logic           neg_reg [0:N];

    logic [NUM_W-1:0] nmag;
    logic [DIV_W-1:0] dmag;
    assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dmag = den[31] ? DIV_W'(-den) : DIV_W'(den);

    // stage 0 capture
    always_ff @(posedge clk)
    begin
        q_reg[0]   <= {nmag, {FRAC_BITS{1'b0}}};
        r_reg[0]   <= '0;
        d_reg[0]   <= dmag;
        neg_reg[0] <= num[NUM_W-1] ^ den[31];
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stg
            logic [DIV_W+1:0] sh;
            logic [DIV_W+1:0] df;
            assign sh = {r_reg[g], q_reg[g][N-1]};
            assign df = sh - {2'b00, d_reg[g]};
            always_ff @(posedge clk)
            begin
                if (!df[DIV_W+1])
                begin
                    r_reg[g+1] <= df[DIV_W:0];
                    q_reg[g+1] <= {q_reg[g][N-2:0], 1'b1};
                end
                else
                begin
                    r_reg[g+1] <= sh[DIV_W:0];
                    q_reg[g+1] <= {q_reg[g][N-2:0], 1'b0};
                end
                d_reg[g+1]   <= d_reg[g];
                neg_reg[g+1] <= neg_reg[g];
            end
        end
    endgenerate

    logic [T_W-1:0] qz;
    always_comb
    begin
        qz = T_W'(q_reg[N]) + T_W'(neg_reg[N] && r_reg[N] != '0);
        quo = neg_reg[N] ? -$signed(qz) : $signed(qz);
    end

    logic unused;
    assign unused = in_vld ^ rst_n ^ clk;
endmodule
`default_nettype wire

// ===== rtl/rbsi_point.sv =====
// Entry point: floor((2*s + size + floor(d*t/2^(F-1)))/2), saturated.
// Partial products are registered; the sum is combinational. Depends on rbsi_pkg.
`default_nettype none
module rbsi_point
    import rbsi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic signed [31:0]    d,
    input  wire logic signed [T_W-1:0] t,
    input  wire logic signed [31:0]    s,
    input  wire logic [30:0]           sz,
    output logic signed [31:0]         p
);
    logic [31:0] a;
    logic [63:0] b;
    logic        neg;
    assign a = d[31] ? 32'(-d) : 32'(d);
    assign b = t[T_W-1] ? 64'(-t) : 64'(t);
    assign neg = d[31] ^ t[T_W-1];

    logic [63:0] hi_reg, lo_reg;
    logic        big_reg, neg_reg;
    logic signed [T_W-1:0] base_reg;
    always_ff @(posedge clk)
    begin
        hi_reg   <= 64'(a) * 64'(b[63:29] > 35'h3ffffffff ? 34'h3ffffffff : b[62:29]);
        lo_reg   <= 64'(a) * 64'(b[28:0]);
        big_reg  <= b[63];
        neg_reg  <= neg;
        base_reg <= 2 * T_W'(s) + T_W'({1'b0, sz});
    end

    logic [63:0] full, q;
    logic signed [T_W-1:0] m, v, h;
    always_comb
    begin
        full = (hi_reg << 29) + lo_reg;
        q = full >> (FRAC_BITS - 1);
        if (neg_reg && full[FRAC_BITS-2:0] != '0)
            q = q + 64'd1;
        if (big_reg || hi_reg >= 64'h200000000 || q > 64'(PROD_CAP))
            q = 64'(PROD_CAP);
        m = neg_reg ? -$signed(q) : $signed(q);
        v = base_reg + m;
        h = v >>> 1;
        p = sat32(h);
    end
endmodule
`default_nettype wire

// ===== rtl/ray_box_slab_intersect.sv =====
// Top level of the ray/box slab intersect block.
// Depends on rbsi_pkg, rbsi_div, rbsi_point.
`default_nettype none
// Usage:
//   Drive the item fields and pulse start while busy is low; busy is always
//   low here, so an item may be given in every cycle.
//   Each item yields exactly one result, shown for one cycle with done high:
//   hit, hit_point_x/y, hit_distance, normal_code. A miss shows all zeros.
//   From start to done: 1 input stage, 50 divider stages for the 50-bit
//   slab quotients, the compare and point stages side by side, then the output register.
//   Throughput: one item per cycle; the bit-per-stage dividers set latency.
//   Four dividers run side by side for near/far on both axes.
//   Reset clears the valid chain only; items in flight are dropped.
//   The receiver cannot stall; results are not held.
module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] src_x,
    input  wire logic signed [31:0] src_y,
    input  wire logic [30:0]        src_w,
    input  wire logic [30:0]        src_h,
    input  wire logic signed [31:0] dir_x,
    input  wire logic signed [31:0] dir_y,
    input  wire logic signed [31:0] box_x,
    input  wire logic signed [31:0] box_y,
    input  wire logic [30:0]        box_w,
    input  wire logic [30:0]        box_h,
    input  wire logic [30:0]        max_dist,
    output logic                    done,
    output logic                    hit,
    output logic signed [31:0]      hit_point_x,
    output logic signed [31:0]      hit_point_y,
    output logic signed [31:0]      hit_distance,
    output logic [2:0]              normal_code
);
    localparam int DLAT = DIVD_W + 1;   // divider latency
    localparam int LAT  = DLAT + 1;     // valid chain length ahead of done

    typedef struct packed {
        logic signed [31:0] sx, sy, dx, dy;
        logic [30:0] sw, sh, md;
        logic okx, oky;   // zero-dir slab holds origin
    } item_t;

    assign busy = 1'b0;

    // stage in: numerators
    logic signed [NUM_W-1:0] nnx, nfx, nny, nfy;
    assign nnx = NUM_W'(box_x) - NUM_W'(src_x) - NUM_W'({1'b0, src_w});
    assign nfx = NUM_W'(box_x) + NUM_W'({1'b0, box_w}) - NUM_W'(src_x);
    assign nny = NUM_W'(box_y) - NUM_W'(src_y) - NUM_W'({1'b0, src_h});
    assign nfy = NUM_W'(box_y) + NUM_W'({1'b0, box_h}) - NUM_W'(src_y);

    logic [LAT-1:0] vld_reg;
    item_t it_reg [0:DLAT-1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        it_reg[0] <= '{src_x, src_y, dir_x, dir_y, src_w, src_h, max_dist,
                       nnx < 0 && nfx > 0, nny < 0 && nfy > 0};
        for (int i = 0; i < DLAT - 1; i++)
            it_reg[i+1] <= it_reg[i];
    end

    logic signed [T_W-1:0] qnx, qfx, qny, qfy;
    rbsi_div u_dnx (.clk, .rst_n, .in_vld(start), .num(nnx), .den(dir_x), .quo(qnx));
    rbsi_div u_dfx (.clk, .rst_n, .in_vld(start), .num(nfx), .den(dir_x), .quo(qfx));
    rbsi_div u_dny (.clk, .rst_n, .in_vld(start), .num(nny), .den(dir_y), .quo(qny));
    rbsi_div u_dfy (.clk, .rst_n, .in_vld(start), .num(nfy), .den(dir_y), .quo(qfy));

    // compare stage
    item_t it;
    logic signed [T_W-1:0] nx, fx, ny, fy, tin, tout;
    logic h_c;
    logic [2:0] c_c;
    always_comb
    begin
        it = it_reg[DLAT - 1];
        h_c = 1'b1;
        if (it.dx == 0)
        begin
            nx = -T_UNB; fx = T_UNB; h_c = h_c & it.okx;
        end
        else if (qnx > qfx)
        begin
            nx = qfx; fx = qnx;
        end
        else
        begin
            nx = qnx; fx = qfx;
        end
        if (it.dy == 0)
        begin
            ny = -T_UNB; fy = T_UNB; h_c = h_c & it.oky;
        end
        else if (qny > qfy)
        begin
            ny = qfy; fy = qny;
        end
        else
        begin
            ny = qny; fy = qfy;
        end
        tin  = nx > ny ? nx : ny;
        tout = fx < fy ? fx : fy;
        if (it.dx == 0 && it.dy == 0) h_c = 1'b0;
        if (nx > fy || ny > fx) h_c = 1'b0;
        if (tout < 0) h_c = 1'b0;
        // signed compare: a negative entry time (origin inside) still counts
        if (!(tin < $signed(T_W'({1'b0, it.md})))) h_c = 1'b0;
        if (nx > ny)
            c_c = it.dx < 0 ? NRM_PX : NRM_NX;
        else if (nx < ny)
            c_c = it.dy < 0 ? NRM_PY : NRM_NY;
        else
            c_c = NRM_NONE;
    end

    logic h1_reg;
    logic [2:0] c1_reg;
    logic signed [31:0] t1_reg;
    always_ff @(posedge clk)
    begin
        h1_reg <= h_c;
        c1_reg <= c_c;
        t1_reg <= sat32(tin);
    end

    logic signed [31:0] px, py;
    rbsi_point u_px (.clk, .d(it.dx), .t(tin), .s(it.sx), .sz(it.sw), .p(px));
    rbsi_point u_py (.clk, .d(it.dy), .t(tin), .s(it.sy), .sz(it.sh), .p(py));

    // output register
    logic done_reg, hit_reg;
    logic signed [31:0] hpx_reg, hpy_reg, hd_reg;
    logic [2:0] nc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[LAT-1];
    end
    always_ff @(posedge clk)
    begin
        hit_reg <= h1_reg;
        hpx_reg <= h1_reg ? px : '0;
        hpy_reg <= h1_reg ? py : '0;
        hd_reg  <= h1_reg ? t1_reg : '0;
        nc_reg  <= h1_reg ? c1_reg : NRM_NONE;
    end

    assign done = done_reg;
    assign hit = hit_reg & done_reg;
    assign hit_point_x = hpx_reg;
    assign hit_point_y = hpy_reg;
    assign hit_distance = hd_reg;
    assign normal_code = nc_reg;

    a_nobusy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-1] |=> done)
        else $error("result lost");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> normal_code == NRM_NONE && hit_distance == 0)
        else $error("miss fields not cleared");
endmodule
`default_nettype wire
